/* sv/tiny_cpu_instruction_execute_assert.svh */
// ----------------------------------------------------------------------------
// tiny cpu assertion macros
// clocked assertion helpers used by the execute unit top file
// ----------------------------------------------------------------------------
`ifndef TINY_CPU_INSTRUCTION_EXECUTE_ASSERT_SVH
`define TINY_CPU_INSTRUCTION_EXECUTE_ASSERT_SVH

// property checked on every rising edge, skipped while reset is high
`define TCE_ASSERT(lbl, clk_sig, rst_sig, prop_expr, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop_expr) \
    else $error(msg);

// property checked on every rising edge, reset included
`define TCE_ASSERT_ALWAYS(lbl, clk_sig, prop_expr, msg) \
  lbl: assert property (@(posedge clk_sig) prop_expr) else $error(msg);

`endif

/* sv/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// opcodes, constants and shared types of the tiny cpu execute unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tce_pkg;

  localparam int NUM_REGS_DEF = 16;
  localparam int WORD_W       = 16;
  localparam int IDX_W        = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  ridx_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'h0,
    OP_CMP = 4'h5,
    OP_CPY = 4'h6,
    OP_OUT = 4'h7,
    OP_LDV = 4'hA,
    OP_JMP = 4'hE
  } opcode_t;

  localparam ridx_t REG_PC    = 4'h0;
  localparam ridx_t REG_FLAGS = 4'h1;

  // jump mode held in field a
  localparam ridx_t JMP_IF_CLEAR = 4'h0;
  localparam ridx_t JMP_IF_SET   = 4'h1;

  localparam word_t PC_STEP   = 16'h0002;
  localparam word_t FLAG_GT   = 16'h0001;
  localparam word_t FLAG_EQ   = 16'h0002;
  localparam word_t FLAG_LT   = 16'h0004;
  localparam word_t FLAG_MASK = 16'h0007;

  // outcome of one instruction
  typedef struct packed {
    word_t pc_next;
    word_t flags_next;
    logic  halted_next;
    logic  ram_we;
    ridx_t ram_widx;
    word_t ram_wdata;
    word_t print_value;
    logic  print_valid;
  } exec_res_t;

endpackage

/* sv/tce_ram.sv */
// ----------------------------------------------------------------------------
// tce_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* sv/tce_regfile.sv */
// ----------------------------------------------------------------------------
// tce_regfile
// general registers on a ram with entry valid bits and write bypass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_regfile #(
  parameter int NumRegs = tce_pkg::NUM_REGS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  tce_pkg::ridx_t ridx_a,
  input  tce_pkg::ridx_t ridx_b,
  input  logic          we,
  input  tce_pkg::ridx_t widx,
  input  tce_pkg::word_t wdata,
  output tce_pkg::word_t rdata_a,
  output tce_pkg::word_t rdata_b
);

  import tce_pkg::*;

  localparam int AW = $clog2(NumRegs);

  logic [NumRegs-1:0] valid;
  logic               we_ok;
  logic               a_ok;
  logic               b_ok;
  logic               a_live;
  logic               b_live;
  logic               byp_a;
  logic               byp_b;
  word_t              byp_data;
  word_t              ram_a;
  word_t              ram_b;

  assign we_ok = we && (int'(widx) < NumRegs);

  tce_ram #(
    .Width (WORD_W),
    .Depth (NumRegs)
  ) u_ram (
    .clk     (clk),
    .we      (we_ok),
    .waddr   (widx[AW-1:0]),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (ridx_a[AW-1:0]),
    .raddr_b (ridx_b[AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we_ok) begin
      valid[widx[AW-1:0]] <= 1'b1;
    end
  end

  // side info registered alongside the ram read
  always_ff @(posedge clk) begin
    if (re) begin
      a_ok     <= int'(ridx_a) < NumRegs;
      b_ok     <= int'(ridx_b) < NumRegs;
      a_live   <= valid[ridx_a[AW-1:0]];
      b_live   <= valid[ridx_b[AW-1:0]];
      byp_a    <= we_ok && (widx == ridx_a);
      byp_b    <= we_ok && (widx == ridx_b);
      byp_data <= wdata;
    end
  end

  always_comb begin
    rdata_a = '0;
    rdata_b = '0;
    if (a_ok) begin
      if (byp_a) begin
        rdata_a = byp_data;
      end else if (a_live) begin
        rdata_a = ram_a;
      end
    end
    if (b_ok) begin
      if (byp_b) begin
        rdata_b = byp_data;
      end else if (b_live) begin
        rdata_b = ram_b;
      end
    end
  end

endmodule

/* sv/tce_exec.sv */
// ----------------------------------------------------------------------------
// tce_exec
// decode and execute of one instruction against pc, flags and operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_exec (
  input  tce_pkg::word_t    instr,
  input  tce_pkg::word_t    operand,
  input  tce_pkg::word_t    pc,
  input  tce_pkg::word_t    flags,
  input  logic              halted_flag,
  input  tce_pkg::word_t    gpr_a,
  input  tce_pkg::word_t    gpr_b,
  output tce_pkg::exec_res_t res
);

  import tce_pkg::*;

  opcode_t op;
  ridx_t   fa;
  ridx_t   fb;
  ridx_t   fc;
  word_t   pc_adv;
  word_t   flags_rd;
  word_t   va;
  word_t   vb;
  word_t   cmp_bits;
  logic    flag_bit;
  logic    take_jump;
  logic    wr_en;
  ridx_t   wr_idx;
  word_t   wr_data;

  assign op = opcode_t'(instr[15:12]);
  assign fa = instr[11:8];
  assign fb = instr[7:4];
  assign fc = instr[3:0];

  assign pc_adv   = pc + PC_STEP;
  // compare sees the flags with its own bits already cleared
  assign flags_rd = (op == OP_CMP) ? (flags & ~FLAG_MASK) : flags;

  assign va = (fa == REG_PC) ? pc_adv : (fa == REG_FLAGS) ? flags_rd : gpr_a;
  assign vb = (fb == REG_PC) ? pc_adv : (fb == REG_FLAGS) ? flags_rd : gpr_b;

  assign cmp_bits = (va > vb) ? FLAG_GT : (va == vb) ? FLAG_EQ : FLAG_LT;
  assign flag_bit = flags[fb];

  always_comb begin
    take_jump = 1'b1;
    if (fa == JMP_IF_CLEAR) begin
      take_jump = !flag_bit;
    end else if (fa == JMP_IF_SET) begin
      take_jump = flag_bit;
    end
  end

  always_comb begin
    res             = '0;
    res.pc_next     = pc_adv;
    res.flags_next  = flags;
    res.halted_next = halted_flag;
    wr_en           = 1'b0;
    wr_idx          = fc;
    wr_data         = '0;

    unique case (op)
      OP_ADD: begin
        wr_en   = 1'b1;
        wr_idx  = fc;
        wr_data = va + vb;
      end
      OP_CMP: begin
        res.flags_next = flags_rd | cmp_bits;
      end
      OP_CPY: begin
        wr_en   = 1'b1;
        wr_idx  = fb;
        wr_data = va;
      end
      OP_OUT: begin
        res.print_value = va;
        res.print_valid = 1'b1;
      end
      OP_LDV: begin
        wr_en   = 1'b1;
        wr_idx  = fa;
        wr_data = operand;
      end
      OP_JMP: begin
        if (take_jump) begin
          res.pc_next = operand;
        end
      end
      default: begin
        res.halted_next = 1'b1;
      end
    endcase

    // register writes land after the pc advance
    if (wr_en) begin
      if (wr_idx == REG_PC) begin
        res.pc_next = wr_data;
      end else if (wr_idx == REG_FLAGS) begin
        res.flags_next = wr_data;
      end else begin
        res.ram_we = 1'b1;
      end
    end
    res.ram_widx  = wr_idx;
    res.ram_wdata = wr_data;

    // halted: instruction ignored, nothing changes
    if (halted_flag) begin
      res             = '0;
      res.pc_next     = pc;
      res.flags_next  = flags;
      res.halted_next = 1'b1;
    end
  end

endmodule

/* sv/tiny_cpu_instruction_execute.sv */
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute
// two-word instruction executor on a sixteen-entry register file
// ----------------------------------------------------------------------------
// Takes one instruction per clock while the output is not stalled and
// returns one result per instruction. The input register holds the
// instruction while the general registers are read from a two-port ram,
// and the result is then loaded into the output register and offered there.
// Pc, flags and the halt bit live in flops;
// the ram has valid bits so entries never written read as zero, and a write
// from the instruction ahead is bypassed into the read. The input side only
// stalls while the output register is full and its transfer is stalled.
`timescale 1ns / 1ps

module tiny_cpu_instruction_execute #(
  parameter int NumRegs = tce_pkg::NUM_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tce_pkg::word_t instruction_word,
  input  tce_pkg::word_t operand_word,
  output logic           out_valid,
  input  logic           out_stall,
  output tce_pkg::word_t next_pc,
  output tce_pkg::word_t print_value,
  output logic           print_valid,
  output logic           halted
);

  import tce_pkg::*;

  logic      s1_v;
  word_t     s1_instr;
  word_t     s1_operand;
  word_t     pc;
  word_t     flags;
  logic      halted_flag;
  logic      in_xfer;
  logic      exec_fire;
  word_t     gpr_a;
  word_t     gpr_b;
  exec_res_t res;

  assign exec_fire = s1_v && (!out_valid || !out_stall);
  assign in_stall  = s1_v && !exec_fire;
  assign in_xfer   = in_valid && !in_stall;

  tce_regfile #(
    .NumRegs (NumRegs)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (in_xfer),
    .ridx_a  (instruction_word[11:8]),
    .ridx_b  (instruction_word[7:4]),
    .we      (exec_fire && res.ram_we),
    .widx    (res.ram_widx),
    .wdata   (res.ram_wdata),
    .rdata_a (gpr_a),
    .rdata_b (gpr_b)
  );

  tce_exec u_exec (
    .instr       (s1_instr),
    .operand     (s1_operand),
    .pc          (pc),
    .flags       (flags),
    .halted_flag (halted_flag),
    .gpr_a       (gpr_a),
    .gpr_b       (gpr_b),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_xfer) begin
      s1_v <= 1'b1;
    end else if (exec_fire) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr   <= instruction_word;
      s1_operand <= operand_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      flags       <= '0;
      halted_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (exec_fire) begin
        pc          <= res.pc_next;
        flags       <= res.flags_next;
        halted_flag <= res.halted_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      next_pc     <= res.pc_next;
      print_value <= res.print_value;
      print_valid <= res.print_valid;
      halted      <= res.halted_next;
    end
  end

  `include "tiny_cpu_instruction_execute_assert.svh"

  `TCE_ASSERT(a_halt_sticky, clk, rst, halted_flag |=> halted_flag, "halt bit cleared")
  `TCE_ASSERT(a_halt_pc_hold, clk, rst, halted_flag |=> $stable(pc), "pc moved while halted")
  `TCE_ASSERT(a_cmp_onehot, clk, rst, (exec_fire && !halted_flag && (s1_instr[15:12] == OP_CMP)) |=> $onehot(flags[2:0]), "compare flags not one-hot")
  `TCE_ASSERT(a_print_not_halted, clk, rst, (out_valid && print_valid) |-> !halted, "print on halted result")
  `TCE_ASSERT_ALWAYS(a_stall_needs_item, clk, in_stall |-> s1_v, "input stalled with empty stage")

endmodule

/* verif/tb_tiny_cpu_instruction_execute.sv */
// ----------------------------------------------------------------------------
// tb_tiny_cpu_instruction_execute
// self-checking bench for the tiny cpu instruction execute unit
// ----------------------------------------------------------------------------
// Drives a directed sequence and then long random runs of legal instructions
// through the execute unit. A scoreboard keeps its own copy of the register
// file and halt bit, predicts each result when an instruction transfer
// happens and compares every result transfer in order. Idle and stall rates
// change between phases, and one long receiver hold-off backs up the
// pipeline. The run ends with a halt and a batch of ignored instructions.
`timescale 1ns / 1ps

module tb_tiny_cpu_instruction_execute;
  import tce_pkg::*;

  typedef struct {
    word_t pc;
    word_t pval;
    logic  pvalid;
    logic  halt;
  } step_out_t;

  class tce_scoreboard;
    word_t       regs[16];
    logic        halt_st;
    step_out_t   expected_q[$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      halt_st = 1'b0;
      errors  = 0;
    endfunction

    // run one instruction on the shadow state and queue its result
    function void note(word_t ins, word_t opw);
      logic [3:0] op;
      ridx_t      fa, fb, fc;
      word_t      x, y;
      step_out_t  r;
      op = ins[15:12];
      fa = ins[11:8];
      fb = ins[7:4];
      fc = ins[3:0];
      r.pval   = '0;
      r.pvalid = 1'b0;
      if (!halt_st) begin
        regs[REG_PC] = regs[REG_PC] + PC_STEP;
        case (op)
          OP_ADD: regs[fc] = regs[fa] + regs[fb];
          OP_CMP: begin
            regs[REG_FLAGS] = regs[REG_FLAGS] & ~FLAG_MASK;
            x = regs[fa];
            y = regs[fb];
            if (x > y) regs[REG_FLAGS] = regs[REG_FLAGS] | FLAG_GT;
            else if (x == y) regs[REG_FLAGS] = regs[REG_FLAGS] | FLAG_EQ;
            else regs[REG_FLAGS] = regs[REG_FLAGS] | FLAG_LT;
          end
          OP_CPY: regs[fb] = regs[fa];
          OP_OUT: begin
            r.pval   = regs[fa];
            r.pvalid = 1'b1;
          end
          OP_LDV: regs[fa] = opw;
          OP_JMP: begin
            if (fa == JMP_IF_CLEAR) begin
              if (!regs[REG_FLAGS][fb]) regs[REG_PC] = opw;
            end else if (fa == JMP_IF_SET) begin
              if (regs[REG_FLAGS][fb]) regs[REG_PC] = opw;
            end else begin
              regs[REG_PC] = opw;
            end
          end
          default: halt_st = 1'b1;
        endcase
      end
      r.pc   = regs[REG_PC];
      r.halt = halt_st;
      expected_q.push_back(r);
    endfunction

    function void check(word_t pc, word_t pval, logic pvalid, logic halt);
      step_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: next_pc %h", pc);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (pc !== e.pc) begin
        $error("next_pc: expected %h, actual %h", e.pc, pc);
        errors++;
      end
      if (pval !== e.pval) begin
        $error("print_value: expected %h, actual %h", e.pval, pval);
        errors++;
      end
      if (pvalid !== e.pvalid) begin
        $error("print_valid: expected %b, actual %b", e.pvalid, pvalid);
        errors++;
      end
      if (halt !== e.halt) begin
        $error("halted: expected %b, actual %b", e.halt, halt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t instruction_word = '0;
  word_t operand_word = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t next_pc;
  word_t print_value;
  logic  print_valid;
  logic  halted;

  tce_scoreboard sb;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_left     = 0;

  // sampled at the falling edge, acted on at the next rising edge
  logic  ov_s, os_s, pvalid_s, halt_s;
  word_t pc_s, pval_s;

  tiny_cpu_instruction_execute i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .instruction_word (instruction_word),
    .operand_word     (operand_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .next_pc          (next_pc),
    .print_value      (print_value),
    .print_valid      (print_valid),
    .halted           (halted)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    ov_s     = out_valid;
    os_s     = out_stall;
    pc_s     = next_pc;
    pval_s   = print_value;
    pvalid_s = print_valid;
    halt_s   = halted;
  end

  always @(posedge clk) begin
    if (!rst && ov_s === 1'b1 && !os_s) sb.check(pc_s, pval_s, pvalid_s, halt_s);
  end

  // receiver: random stalls, or a long counted hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  function automatic word_t encode(logic [3:0] op, ridx_t a, ridx_t b, ridx_t c);
    return {op, a, b, c};
  endfunction

  function automatic word_t rand_operand();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return word_t'($urandom_range(15));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic is_legal_op(logic [3:0] op);
    case (op)
      OP_ADD, OP_CMP, OP_CPY, OP_OUT, OP_LDV, OP_JMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_instr(input word_t ins, input word_t opw);
    logic stalled;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    instruction_word <= ins;
    operand_word     <= opw;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sb.note(ins, opw);
  endtask

  task automatic send_random_legal();
    logic [3:0] op;
    ridx_t      a, b, c;
    case ($urandom_range(5))
      0:       op = OP_ADD;
      1:       op = OP_CMP;
      2:       op = OP_CPY;
      3:       op = OP_OUT;
      4:       op = OP_LDV;
      default: op = OP_JMP;
    endcase
    a = ridx_t'($urandom);
    b = ($urandom_range(3) == 0) ? a : ridx_t'($urandom);
    c = ridx_t'($urandom);
    if (op == OP_JMP) begin
      case ($urandom_range(2))
        0:       a = JMP_IF_CLEAR;
        1:       a = JMP_IF_SET;
        default: a = ridx_t'($urandom);
      endcase
    end
    send_instr(encode(op, a, b, c), rand_operand());
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n) send_random_legal();
  endtask

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [3:0] halt_op;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wrap, compares, flag reads, jumps, pc writes
    send_instr(encode(OP_LDV, 4'h2, 4'h0, 4'h0), 16'hFFFF);
    send_instr(encode(OP_LDV, 4'h3, 4'h0, 4'h0), 16'h0001);
    send_instr(encode(OP_ADD, 4'h2, 4'h3, 4'h4), 16'h0000);
    send_instr(encode(OP_OUT, 4'h4, 4'h0, 4'h0), 16'hFFFF);
    send_instr(encode(OP_OUT, REG_PC, 4'h0, 4'h0), 16'h0000);
    send_instr(encode(OP_CMP, 4'h2, 4'h3, 4'h0), 16'h0000);
    send_instr(encode(OP_CMP, 4'h3, 4'h2, 4'h0), 16'h0000);
    send_instr(encode(OP_CMP, 4'h4, 4'h4, 4'h0), 16'h0000);
    send_instr(encode(OP_CMP, REG_FLAGS, 4'h5, 4'h0), 16'h0000);
    send_instr(encode(OP_LDV, REG_FLAGS, 4'h0, 4'h0), 16'hFFF8);
    send_instr(encode(OP_CMP, REG_FLAGS, 4'h2, 4'h0), 16'h0000);
    send_instr(encode(OP_OUT, REG_FLAGS, 4'h0, 4'h0), 16'h0000);
    send_instr(encode(OP_JMP, JMP_IF_CLEAR, 4'h2, 4'h0), 16'h1234);
    send_instr(encode(OP_JMP, JMP_IF_SET, 4'h2, 4'h0), 16'h1234);
    send_instr(encode(OP_JMP, JMP_IF_SET, 4'hF, 4'h0), 16'hABCD);
    send_instr(encode(OP_JMP, JMP_IF_CLEAR, 4'h0, 4'h0), 16'h4321);
    send_instr(encode(OP_JMP, 4'hF, 4'hF, 4'hF), 16'hFFFE);
    send_instr(encode(OP_OUT, REG_PC, 4'h0, 4'h0), 16'h0000);
    send_instr(encode(OP_CPY, 4'h2, REG_PC, 4'h0), 16'h0000);
    send_instr(encode(OP_ADD, 4'h2, 4'h3, REG_PC), 16'h0000);
    send_instr(encode(OP_LDV, REG_PC, 4'h0, 4'h0), 16'h8000);
    send_instr(encode(OP_LDV, 4'hF, 4'h0, 4'h0), 16'h5A5A);
    send_instr(encode(OP_CPY, 4'hF, 4'hE, 4'h0), 16'h0000);
    send_instr(encode(OP_OUT, 4'hE, 4'h0, 4'h0), 16'h0000);

    // back-to-back, then phases with idle and stall rates, with one long hold-off to fill the pipe
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (100) send_random_legal();
    hold_left = 60;
    run_phase(0, 0, 380);
    run_phase(85, 0, 480);
    run_phase(0, 85, 480);
    run_phase(28, 28, 480);

    // halt, then instructions that must be ignored
    do halt_op = 4'($urandom); while (is_legal_op(halt_op));
    send_instr(encode(halt_op, ridx_t'($urandom), ridx_t'($urandom),
                      ridx_t'($urandom)), word_t'($urandom));
    in_idle_pct   = 20;
    out_stall_pct = 20;
    repeat (40) send_instr(word_t'($urandom), word_t'($urandom));
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/tce_pkg.sv
sv/tce_ram.sv
sv/tce_regfile.sv
sv/tce_exec.sv
sv/tiny_cpu_instruction_execute.sv
verif/tb_tiny_cpu_instruction_execute.sv
